// File: rtl/xrng_pkg.sv
package xrng_pkg;

    localparam int unsigned WordW  = 64;
    localparam int unsigned BoundW = 32;
    localparam int unsigned RndW   = 31;  // top bits of a draw used for bounded results

    localparam logic [WordW-1:0] SeedSubA = 64'h6A09_E667_F3BC_C909;
    localparam logic [WordW-1:0] SeedSubB = 64'h9E37_79B9_7F4A_7C15;

    localparam int unsigned RotSum = 17;
    localparam int unsigned RotA   = 49;
    localparam int unsigned ShB    = 21;
    localparam int unsigned RotB   = 28;

    // func codes carried on tuser
    localparam logic FuncRaw     = 1'b0;
    localparam logic FuncBounded = 1'b1;

    // register indexes (paddr[3])
    localparam logic RegSeedLow  = 1'b0;
    localparam logic RegSeedHigh = 1'b1;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_DRAW,
        ST_EVAL,
        ST_MUL,
        ST_DIV,
        ST_DONE
    } t_state;

    typedef struct packed {
        logic load;
        logic step;
    } t_gen_ctl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

    function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] v,
                                              input int unsigned n);
        rotl = (v << n) | (v >> (WordW - n));
    endfunction

endpackage

// File: rtl/xoroshiro128pp_bounded_rng.sv
// Path from accept to output valid: a raw draw passes DRAW, EVAL and DONE; bound <= 0
// goes straight to DONE; a power-of-two bound adds MUL; other bounds wait in DIV on the
// one-bit-per-cycle remainder unit (31 steps) and go back to DRAW for each rejected draw.
// One word at a time: ready returns with output valid as the result enters the output
// register; a finished word waits in DONE while that register is full.
// Synchronous active-low reset; state loads the fixed substitute seeds.
module xoroshiro128pp_bounded_rng
    import xrng_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    input  logic [BoundW-1:0] i_s_axis_tdata,   // [31:0] bound
    input  logic [0:0]        i_s_axis_tuser,   // [0] func
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    output logic [WordW-1:0]  o_m_axis_tdata,   // [63:0] value
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [3:0]        paddr,
    input  logic [WordW-1:0]  pwdata,
    output logic [WordW-1:0]  prdata,
    output logic              pready
);

    t_state           r_state, n_state;
    logic             r_func, n_func;
    logic [RndW-1:0]  r_bound, n_bound;
    logic [RndW-1:0]  r_rnd, n_rnd;
    logic [WordW-1:0] r_result, n_result;
    logic             r_out_valid, n_out_valid;
    logic [WordW-1:0] r_out_data, n_out_data;
    logic [WordW-1:0] r_seed_low, r_seed_high, n_seed_low, n_seed_high;

    t_gen_ctl         w_gen_ctl;
    t_div_stat        w_div_stat;
    logic [WordW-1:0] w_draw;
    logic [RndW-1:0]  w_rem;
    logic             w_div_start;
    logic             w_wr;
    logic             w_in_acc;
    logic             w_pow2;
    logic [2*RndW-1:0] w_prod;
    logic [RndW:0]    w_chk;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign prdata = (paddr[3] == RegSeedHigh) ? r_seed_high : r_seed_low;

    always_comb begin
        n_seed_low  = r_seed_low;
        n_seed_high = r_seed_high;
        if (w_wr) begin
            if (paddr[3] == RegSeedLow) begin
                n_seed_low = pwdata;
            end else begin
                n_seed_high = pwdata;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_seed_low  <= '0;
            r_seed_high <= '0;
        end else begin
            r_seed_low  <= n_seed_low;
            r_seed_high <= n_seed_high;
        end
    end

    xrng_gen u_gen (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_ctl       (w_gen_ctl),
        .i_seed_low  (n_seed_low),
        .i_seed_high (n_seed_high),
        .o_draw      (w_draw)
    );

    xrng_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (w_div_start),
        .i_dividend (w_draw[WordW-1 -: RndW]),
        .i_divisor  (r_bound),
        .o_rem      (w_rem),
        .o_stat     (w_div_stat)
    );

    assign o_s_axis_tready = (r_state == ST_IDLE);
    assign w_in_acc        = i_s_axis_tvalid && o_s_axis_tready;
    assign w_pow2          = (r_bound & (r_bound - 1'b1)) == '0;
    assign w_prod          = r_bound * r_rnd;
    // draw - rem + (bound - 1) must stay below 2^31 for the draw to be kept
    assign w_chk           = {1'b0, r_rnd - w_rem} + {1'b0, r_bound - 1'b1};

    always_comb begin
        n_state        = r_state;
        n_func         = r_func;
        n_bound        = r_bound;
        n_rnd          = r_rnd;
        n_result       = r_result;
        n_out_valid    = r_out_valid && !i_m_axis_tready;
        n_out_data     = r_out_data;
        w_gen_ctl.load = w_wr;
        w_gen_ctl.step = 1'b0;
        w_div_start    = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (w_in_acc) begin
                    n_func  = i_s_axis_tuser[0];
                    n_bound = i_s_axis_tdata[RndW-1:0];
                    if (i_s_axis_tuser[0] == FuncBounded &&
                        (i_s_axis_tdata[BoundW-1] || i_s_axis_tdata == '0)) begin
                        n_result = '0;
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_DRAW: begin
                w_gen_ctl.step = 1'b1;
                n_state        = ST_EVAL;
            end
            ST_EVAL: begin
                n_rnd = w_draw[WordW-1 -: RndW];
                if (r_func == FuncRaw) begin
                    n_result = w_draw;
                    n_state  = ST_DONE;
                end else if (w_pow2) begin
                    n_state = ST_MUL;
                end else begin
                    w_div_start = 1'b1;
                    n_state     = ST_DIV;
                end
            end
            ST_MUL: begin
                n_result = {{(WordW-RndW){1'b0}}, w_prod[2*RndW-1 -: RndW]};
                n_state  = ST_DONE;
            end
            ST_DIV: begin
                if (w_div_stat.done) begin
                    if (!w_chk[RndW]) begin
                        n_result = {{(WordW-RndW){1'b0}}, w_rem};
                        n_state  = ST_DONE;
                    end else begin
                        n_state = ST_DRAW;
                    end
                end
            end
            ST_DONE: begin
                if (!r_out_valid || i_m_axis_tready) begin
                    n_out_valid = 1'b1;
                    n_out_data  = r_result;
                    n_state     = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_func     <= n_func;
        r_bound    <= n_bound;
        r_rnd      <= n_rnd;
        r_result   <= n_result;
        r_out_data <= n_out_data;
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_data;

endmodule

// File: rtl/xrng_gen.sv
module xrng_gen
    import xrng_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  t_gen_ctl         i_ctl,
    input  logic [WordW-1:0] i_seed_low,
    input  logic [WordW-1:0] i_seed_high,
    output logic [WordW-1:0] o_draw
);

    logic [WordW-1:0] r_a, r_b, r_draw;
    logic [WordW-1:0] n_a, n_b;
    logic [WordW-1:0] w_sum, w_res, w_x;
    logic             w_zero;

    always_comb begin
        w_sum  = r_a + r_b;
        w_res  = rotl(w_sum, RotSum) + r_a;
        w_x    = r_a ^ r_b;
        w_zero = (i_seed_low == '0) && (i_seed_high == '0);
        n_a    = r_a;
        n_b    = r_b;
        if (i_ctl.load) begin
            n_a = w_zero ? SeedSubA : i_seed_low;
            n_b = w_zero ? SeedSubB : i_seed_high;
        end else if (i_ctl.step) begin
            n_a = rotl(r_a, RotA) ^ w_x ^ (w_x << ShB);
            n_b = rotl(w_x, RotB);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a <= SeedSubA;
            r_b <= SeedSubB;
        end else begin
            r_a <= n_a;
            r_b <= n_b;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.step) begin
            r_draw <= w_res;
        end
    end

    assign o_draw = r_draw;

endmodule

// File: rtl/xrng_div.sv
module xrng_div
    import xrng_pkg::*;
(
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_start,
    input  logic [RndW-1:0] i_dividend,
    input  logic [RndW-1:0] i_divisor,
    output logic [RndW-1:0] o_rem,
    output t_div_stat       o_stat
);

    localparam int unsigned CntW = $clog2(RndW);

    logic [RndW-1:0] r_rem, r_dvd, r_dsr;
    logic [CntW-1:0] r_cnt;
    logic            r_busy, r_done;
    logic [RndW:0]   w_trial;
    logic            w_ge;

    // one restoring step per cycle, dividend bits enter msb first
    always_comb begin
        w_trial = {r_rem, r_dvd[RndW-1]};
        w_ge    = w_trial >= {1'b0, r_dsr};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= CntW'(RndW - 1);
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= '0;
            r_dvd <= i_dividend;
            r_dsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= w_ge ? RndW'(w_trial - {1'b0, r_dsr}) : w_trial[RndW-1:0];
            r_dvd <= r_dvd << 1;
        end
    end

    assign o_rem       = r_rem;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

endmodule

// File: rtl/xrng_checker.sv
module xrng_checker
    import xrng_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_s_axis_tvalid,
    input logic              o_s_axis_tready,
    input logic              o_m_axis_tvalid,
    input logic              i_m_axis_tready,
    input logic [WordW-1:0]  o_m_axis_tdata,
    input logic              pready
);

    // a stalled output word holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_axis_tvalid && !i_m_axis_tready |=> o_m_axis_tvalid && $stable(o_m_axis_tdata))
        else $error("output word changed while stalled");

    a_pready: assert property (@(posedge i_clk) disable iff (!i_rst_n) pready)
        else $error("pready dropped");

    // one word in flight: ready drops after an accept
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !o_s_axis_tready)
        else $error("second word accepted while busy");

    // no result can appear in the cycle right after an accept
    a_min_latency: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_s_axis_tvalid && o_s_axis_tready |=> !(o_m_axis_tvalid && !$past(o_m_axis_tvalid)))
        else $error("result appeared too early");

endmodule

bind xoroshiro128pp_bounded_rng xrng_checker u_xrng_checker (
    .i_clk           (i_clk),
    .i_rst_n         (i_rst_n),
    .i_s_axis_tvalid (i_s_axis_tvalid),
    .o_s_axis_tready (o_s_axis_tready),
    .o_m_axis_tvalid (o_m_axis_tvalid),
    .i_m_axis_tready (i_m_axis_tready),
    .o_m_axis_tdata  (o_m_axis_tdata),
    .pready          (pready)
);
